// ----- rtl/core/biou_pkg.sv -----
// biou_pkg: shared widths, register map and beat types for box_iou_gate
// no dependencies; imported by box_iou_gate, biou_score_checker and tb_top
`default_nettype none

package biou_pkg;

	// field widths
	localparam int COORD_BITS  = 12;
	localparam int CLASS_BITS  = 8;
	localparam int FRAC_BITS   = 16;
	localparam int SCORE_BITS  = FRAC_BITS + 1;
	localparam int THRESH_BITS = 17;

	// score of exactly one in fixed point
	localparam logic [SCORE_BITS-1:0] ONE_FIXED = SCORE_BITS'(1) << FRAC_BITS;

	// register map, one 32-bit word each
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam logic [0:0] REG_CLASS_AWARE     = 1'b0;
	localparam logic [0:0] REG_MATCH_THRESHOLD = 1'b1;

	localparam logic                   CLASS_AWARE_RST     = 1'b1;
	localparam logic [THRESH_BITS-1:0] MATCH_THRESHOLD_RST = THRESH_BITS'(19661);

	typedef struct packed {
		logic [COORD_BITS-1:0] trk_left;
		logic [COORD_BITS-1:0] trk_top;
		logic [COORD_BITS-1:0] trk_right;
		logic [COORD_BITS-1:0] trk_bottom;
		logic [CLASS_BITS-1:0] trk_class;
		logic [COORD_BITS-1:0] det_left;
		logic [COORD_BITS-1:0] det_top;
		logic [COORD_BITS-1:0] det_right;
		logic [COORD_BITS-1:0] det_bottom;
		logic [CLASS_BITS-1:0] det_class;
	} biou_in_t;

	typedef struct packed {
		logic [SCORE_BITS-1:0] overlap_score;
		logic                  is_match;
		logic                  saturated;
	} biou_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/box_iou_gate.sv -----
// box_iou_gate: pipelined intersection over union of a track and a detection box
// depends on biou_pkg (widths, register map, beat types)
//
// usage
// - pair channel (pair_valid / pair_stall / pair) carries one track box and one
//   detection box per beat; score channel (score_valid / score_stall / score)
//   returns exactly one result beat per pair beat, in order
// - a beat moves at a rising edge where valid is high and stall is low
// - the apb port holds the class gate enable (byte address 0) and match_threshold
//   (byte address 4); pready is tied high; write only while the pipe is empty
// - a pair beat passes these registered stages on its way to its score beat on the
//   output register: edge extents, area multiply, union add, first quotient bit, eight
//   radix-4 divider stages, final select and threshold compare
// - throughput is one pair per cycle while score_stall is low, set by the
//   restoring divider laid out as two quotient bits per stage rather than iterated
// - a stalled score holds in the output register; the stages behind it keep
//   filling empty slots, so pair_stall only rises once every stage is full
// - reset clears the stage valid bits and loads the register reset values;
//   no clearing pass is needed
`default_nettype none

module box_iou_gate (
	input  wire                             clk,
	input  wire                             arst_n,
	// pair channel
	input  wire                             pair_valid,
	output logic                            pair_stall,
	input  wire biou_pkg::biou_in_t         pair,
	// score channel
	output logic                            score_valid,
	input  wire                             score_stall,
	output biou_pkg::biou_out_t             score,
	// configuration
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [biou_pkg::PADDR_BITS-1:0]  paddr,
	input  wire [biou_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [biou_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready
);
	import biou_pkg::*;

	// derived widths
	localparam int DW   = COORD_BITS + 1;       // signed box extent
	localparam int AW   = 2 * DW;               // signed box area
	localparam int IW   = 2 * COORD_BITS;       // intersection area
	localparam int UW   = AW + 1;               // signed union area
	localparam int DVW  = AW;                   // divisor and remainder
	localparam int QW   = SCORE_BITS;           // quotient

	// divider layout: first quotient bit in stage 4, the rest two per stage
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = (FRAC_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
	localparam int DIV_FIRST     = 4;
	localparam int NSTG          = DIV_FIRST + DIV_STAGES + 1;

	typedef struct packed {
		logic signed [DW-1:0]  tw;
		logic signed [DW-1:0]  th;
		logic signed [DW-1:0]  dw;
		logic signed [DW-1:0]  dh;
		logic [COORD_BITS-1:0] iw;
		logic [COORD_BITS-1:0] ih;
		logic                  gate;
	} s1_t;

	typedef struct packed {
		logic signed [AW-1:0] at;
		logic signed [AW-1:0] ad;
		logic [IW-1:0]        inter;
		logic                 gate;
	} s2_t;

	typedef struct packed {
		logic signed [UW-1:0] uni;
		logic [IW-1:0]        inter;
		logic                 gate;
	} s3_t;

	typedef struct packed {
		logic [DVW-1:0] rem;
		logic [DVW-1:0] dvs;
		logic [QW-1:0]  quo;
		logic           zero;
		logic           sat;
	} div_t;

	// configuration registers
	logic                   gate_en_q;
	logic [THRESH_BITS-1:0] thr_q;
	logic [0:0]             reg_idx;

	// pipeline state
	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] ld;
	s1_t             d_s1;
	s2_t             d_s2;
	s3_t             d_s3;
	div_t            div_s [DIV_STAGES+1];
	biou_out_t       out_s;

	// ---------------------------------------------------------------
	// apb register file
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_en_q <= CLASS_AWARE_RST;
			thr_q     <= MATCH_THRESHOLD_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_CLASS_AWARE:     gate_en_q <= pwdata[0];
				REG_MATCH_THRESHOLD: thr_q     <= pwdata[THRESH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CLASS_AWARE:     prdata = {{(PDATA_BITS-1){1'b0}}, gate_en_q};
			REG_MATCH_THRESHOLD: prdata = {{(PDATA_BITS-THRESH_BITS){1'b0}}, thr_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// flow control: a stage loads when some stage from it to the output,
	// itself included, is empty or the output beat is leaving
	// ---------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < NSTG; i++) begin
			ld[i] = !score_stall || !(&(vld_s | ~({NSTG{1'b1}} << i)));
		end
	end

	assign pair_stall  = !ld[0];
	assign score_valid = vld_s[NSTG-1];
	assign score       = out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[0]) begin
				vld_s[0] <= pair_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (ld[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: box extents, overlap extents clamped at zero, class gate
	// ---------------------------------------------------------------
	logic [COORD_BITS-1:0] ix_lo, ix_hi, iy_lo, iy_hi;

	always_comb begin
		ix_lo = (pair.trk_left  > pair.det_left)   ? pair.trk_left   : pair.det_left;
		ix_hi = (pair.trk_right < pair.det_right)  ? pair.trk_right  : pair.det_right;
		iy_lo = (pair.trk_top   > pair.det_top)    ? pair.trk_top    : pair.det_top;
		iy_hi = (pair.trk_bottom < pair.det_bottom) ? pair.trk_bottom : pair.det_bottom;
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			d_s1.tw   <= $signed({1'b0, pair.trk_right})  - $signed({1'b0, pair.trk_left});
			d_s1.th   <= $signed({1'b0, pair.trk_bottom}) - $signed({1'b0, pair.trk_top});
			d_s1.dw   <= $signed({1'b0, pair.det_right})  - $signed({1'b0, pair.det_left});
			d_s1.dh   <= $signed({1'b0, pair.det_bottom}) - $signed({1'b0, pair.det_top});
			d_s1.iw   <= (ix_hi > ix_lo) ? ix_hi - ix_lo : '0;
			d_s1.ih   <= (iy_hi > iy_lo) ? iy_hi - iy_lo : '0;
			d_s1.gate <= gate_en_q && (pair.trk_class != pair.det_class);
		end
	end

	// ---------------------------------------------------------------
	// stage 2: the three area products, one multiplier each
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			d_s2.at    <= d_s1.tw * d_s1.th;
			d_s2.ad    <= d_s1.dw * d_s1.dh;
			d_s2.inter <= d_s1.iw * d_s1.ih;
			d_s2.gate  <= d_s1.gate;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: union = both areas less the overlap
	// ---------------------------------------------------------------
	logic signed [UW-1:0] at_x, ad_x, in_x;

	always_comb begin
		at_x = {{(UW-AW){d_s2.at[AW-1]}}, d_s2.at};
		ad_x = {{(UW-AW){d_s2.ad[AW-1]}}, d_s2.ad};
		in_x = {{(UW-IW){1'b0}}, d_s2.inter};
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			d_s3.uni   <= at_x + ad_x - in_x;
			d_s3.inter <= d_s2.inter;
			d_s3.gate  <= d_s2.gate;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: zero and saturate decisions, top quotient bit
	// overlap above union saturates, otherwise the integer bit is 1 only when equal
	// ---------------------------------------------------------------
	logic signed [UW-1:0] inter_u;
	logic [DVW-1:0]       inter_d, dvs4;
	logic                 zero4, gt4, ge4;

	always_comb begin
		inter_u = {{(UW-IW){1'b0}}, d_s3.inter};
		inter_d = {{(DVW-IW){1'b0}}, d_s3.inter};
		dvs4    = d_s3.uni[DVW-1:0];
		zero4   = d_s3.gate || d_s3.uni[UW-1] || (d_s3.uni == '0);
		gt4     = inter_u > d_s3.uni;
		ge4     = inter_u >= d_s3.uni;
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			div_s[0].rem  <= ge4 ? inter_d - dvs4 : inter_d;
			div_s[0].dvs  <= dvs4;
			div_s[0].quo  <= {{(QW-1){1'b0}}, ge4};
			div_s[0].zero <= zero4;
			div_s[0].sat  <= !zero4 && gt4;
		end
	end

	// ---------------------------------------------------------------
	// restoring divider, DIV_PER_STAGE fraction bits per stage
	// ---------------------------------------------------------------
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		div_t nxt;

		always_comb begin
			logic [DVW:0] r2;
			nxt = div_s[g];
			r2  = '0;
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				if (g * DIV_PER_STAGE + j < FRAC_BITS) begin
					r2 = {nxt.rem, 1'b0};
					if (r2 >= {1'b0, nxt.dvs}) begin
						r2      = r2 - {1'b0, nxt.dvs};
						nxt.quo = {nxt.quo[QW-2:0], 1'b1};
					end else begin
						nxt.quo = {nxt.quo[QW-2:0], 1'b0};
					end
					nxt.rem = r2[DVW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[DIV_FIRST+g]) begin
				div_s[g+1] <= nxt;
			end
		end
	end

	// ---------------------------------------------------------------
	// output stage: pick the score and compare with the threshold
	// ---------------------------------------------------------------
	logic [QW-1:0] score_sel;

	always_comb begin
		priority if (div_s[DIV_STAGES].zero) begin
			score_sel = '0;
		end else if (div_s[DIV_STAGES].sat) begin
			score_sel = ONE_FIXED;
		end else begin
			score_sel = div_s[DIV_STAGES].quo;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[NSTG-1]) begin
			out_s.overlap_score <= score_sel;
			out_s.is_match      <= score_sel >= thr_q;
			out_s.saturated     <= div_s[DIV_STAGES].sat;
		end
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> vld_s[0])
		else $error("pair stalled with stage 1 empty");

	a_score_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |-> (score.overlap_score <= ONE_FIXED))
		else $error("score above one");

	a_sat_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid && score.saturated) |-> (score.overlap_score == ONE_FIXED))
		else $error("saturated beat without a score of one");

	a_match_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |-> (score.is_match == (score.overlap_score >= thr_q)))
		else $error("match flag disagrees with threshold");

endmodule

`default_nettype wire

// ----- tb/sv/biou_score_checker.sv -----
// biou_score_checker: watches the pair, score and apb channels of box_iou_gate,
// predicts each score beat and compares it; depends on biou_pkg
module biou_score_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pair_valid,
	input  logic                            pair_stall,
	input  biou_pkg::biou_in_t              pair,
	input  logic                            score_valid,
	input  logic                            score_stall,
	input  biou_pkg::biou_out_t             score,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [biou_pkg::PADDR_BITS-1:0] paddr,
	input  logic [biou_pkg::PDATA_BITS-1:0] pwdata,
	output int                              errors,
	output int                              pending
);
	import biou_pkg::*;

	// shadow copy of the register file
	logic                   gate_on;
	logic [THRESH_BITS-1:0] match_thr;

	// expected beats in arrival order, written at due_wr and read at due_rd
	biou_out_t scores_due[int];
	int        due_wr;
	int        due_rd;

	function automatic biou_out_t iou_score(biou_in_t p);
		longint    tl, tt, tr, tb, dl, dt, dr, db;
		longint    iw, ih, ovl_area, uni_area;
		biou_out_t r;
		r = '0;
		if (!(gate_on && p.trk_class != p.det_class)) begin
			tl = longint'(p.trk_left);
			tt = longint'(p.trk_top);
			tr = longint'(p.trk_right);
			tb = longint'(p.trk_bottom);
			dl = longint'(p.det_left);
			dt = longint'(p.det_top);
			dr = longint'(p.det_right);
			db = longint'(p.det_bottom);
			iw = ((tr < dr) ? tr : dr) - ((tl > dl) ? tl : dl);
			ih = ((tb < db) ? tb : db) - ((tt > dt) ? tt : dt);
			if (iw < 0) iw = 0;
			if (ih < 0) ih = 0;
			ovl_area = iw * ih;
			// areas are signed, so inverted boxes can shrink the union
			uni_area = (tr - tl) * (tb - tt) + (dr - dl) * (db - dt) - ovl_area;
			if (uni_area > 0) begin
				if (ovl_area > uni_area) begin
					r.overlap_score = ONE_FIXED;
					r.saturated     = 1'b1;
				end else begin
					r.overlap_score = SCORE_BITS'((ovl_area << FRAC_BITS) / uni_area);
				end
			end
		end
		r.is_match = (THRESH_BITS'(r.overlap_score) >= match_thr);
		return r;
	endfunction

	task automatic report(input string msg);
		$display("score mismatch: %s", msg);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		biou_out_t want;
		if (!arst_n) begin
			gate_on   = CLASS_AWARE_RST;
			match_thr = MATCH_THRESHOLD_RST;
			scores_due.delete();
			due_wr = 0;
			due_rd = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_CLASS_AWARE, 2'b00})
					gate_on = pwdata[0];
				else if (paddr == {REG_MATCH_THRESHOLD, 2'b00})
					match_thr = pwdata[THRESH_BITS-1:0];
			end
			if (score_valid && !score_stall) begin
				if (due_wr == due_rd) begin
					report($sformatf("unexpected beat score=%0d", score.overlap_score));
				end else begin
					want = scores_due[due_rd];
					scores_due.delete(due_rd);
					due_rd++;
					if (score.overlap_score !== want.overlap_score)
						report($sformatf("overlap_score got %0d want %0d",
							score.overlap_score, want.overlap_score));
					if (score.is_match !== want.is_match)
						report($sformatf("is_match got %0b want %0b",
							score.is_match, want.is_match));
					if (score.saturated !== want.saturated)
						report($sformatf("saturated got %0b want %0b",
							score.saturated, want.saturated));
				end
			end
			if (pair_valid && !pair_stall) begin
				scores_due[due_wr] = iou_score(pair);
				due_wr++;
			end
		end
		pending = due_wr - due_rd;
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: stimulus and verdict for box_iou_gate; directed box pairs, then random
// phases over several register settings; depends on biou_pkg and biou_score_checker
module tb_top;
	import biou_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_BEATS  = 125;
	localparam int SETTLE       = 16;   // a little over the pipe depth
	localparam int HOLD_CYCLES  = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  pair_valid;
	logic                  pair_stall;
	biou_in_t              pair;
	logic                  score_valid;
	logic                  score_stall;
	biou_out_t             score;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	int errors;
	int pending;
	int cycles;

	// idling percentages, changed per phase by the stimulus process
	int tx_pct;
	int rx_pct;

	// long receiver hold-off, requested once by the stimulus
	logic hold_req;
	logic hold_done;
	int   hold_left;

	box_iou_gate i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.score_valid(score_valid),
		.score_stall(score_stall),
		.score      (score),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	biou_score_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.score_valid(score_valid),
		.score_stall(score_stall),
		.score      (score),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.errors     (errors),
		.pending    (pending)
	);

	// clock, period 12
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run-away guard
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stall per cycle, plus one long hold-off so the pipe backs up
	initial begin
		score_stall = 1'b0;
		hold_done   = 1'b0;
		hold_left   = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				score_stall = 1'b1;
				hold_left--;
			end else begin
				score_stall = ($urandom_range(99) < rx_pct);
			end
		end
	end

	function automatic biou_in_t box_pair(
		input int tl, input int tt, input int tr, input int tb, input int tc,
		input int dl, input int dt, input int dr, input int db, input int dc);
		biou_in_t p;
		p.trk_left   = COORD_BITS'(tl);
		p.trk_top    = COORD_BITS'(tt);
		p.trk_right  = COORD_BITS'(tr);
		p.trk_bottom = COORD_BITS'(tb);
		p.trk_class  = CLASS_BITS'(tc);
		p.det_left   = COORD_BITS'(dl);
		p.det_top    = COORD_BITS'(dt);
		p.det_right  = COORD_BITS'(dr);
		p.det_bottom = COORD_BITS'(db);
		p.det_class  = CLASS_BITS'(dc);
		return p;
	endfunction

	// mostly small boxes, now and then one up to the full frame
	function automatic int box_len();
		return ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(64);
	endfunction

	function automatic int clip_coord(input int v);
		return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
	endfunction

	// corner nudged by up to about half the box size either way
	function automatic int nudge(input int v, input int len);
		return clip_coord(v + $urandom_range(len + 2) - (len / 2 + 1));
	endfunction

	function automatic biou_in_t random_pair();
		int       kind, tw, th, tl, tt, tr, tb, cls, tmp;
		biou_in_t p;
		kind = $urandom_range(99);
		if (kind < 15) begin
			// noise: every field free
			p = box_pair($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
				$urandom_range(4095), $urandom_range(255), $urandom_range(4095),
				$urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
				$urandom_range(255));
		end else begin
			tw  = box_len();
			th  = box_len();
			tl  = $urandom_range(4095 - tw);
			tt  = $urandom_range(4095 - th);
			tr  = tl + tw;
			tb  = tt + th;
			cls = $urandom_range(255);
			if (kind < 22) begin
				// exact copy, score of one unless the box is empty
				p = box_pair(tl, tt, tr, tb, cls, tl, tt, tr, tb, cls);
			end else begin
				p = box_pair(tl, tt, tr, tb, cls, nudge(tl, tw), nudge(tt, th),
					nudge(tr, tw), nudge(tb, th),
					($urandom_range(9) < 7) ? cls : $urandom_range(255));
			end
			if (kind >= 22 && kind < 28) begin
				// degenerate track box, corners swapped
				tmp         = p.trk_left;
				p.trk_left  = p.trk_right;
				p.trk_right = COORD_BITS'(tmp);
			end
		end
		return p;
	endfunction

	// one beat on the pair channel, idling before it at the current rate
	task automatic send_pair(input biou_in_t p);
		@(negedge clk);
		while ($urandom_range(99) < tx_pct) begin
			pair_valid = 1'b0;
			@(negedge clk);
		end
		pair_valid = 1'b1;
		pair       = p;
		do @(posedge clk); while (pair_stall);
	endtask

	// stop offering and wait for every score to come back
	task automatic drain_pipe();
		@(negedge clk);
		pair_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_write(input logic [0:0] idx, input logic [PDATA_BITS-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	initial begin
		biou_in_t              directed_pairs[$];
		logic                  aware_set[6];
		logic [THRESH_BITS-1:0] thr_set[6];
		logic [PDATA_BITS-1:0] word;

		arst_n     = 1'b0;
		pair_valid = 1'b0;
		pair       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		tx_pct     = 0;
		rx_pct     = 0;
		hold_req   = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed pairs under the reset register values
		directed_pairs = '{
			box_pair(100, 100, 200, 200, 3, 100, 100, 200, 200, 3),    // identical
			box_pair(100, 100, 200, 200, 3, 150, 150, 250, 250, 3),    // partial overlap
			box_pair(0, 0, 10, 10, 1, 20, 20, 30, 30, 1),              // disjoint
			box_pair(0, 0, 10, 10, 1, 10, 0, 20, 10, 1),               // sharing an edge
			box_pair(100, 100, 200, 200, 7, 100, 100, 200, 200, 9),    // class gate
			box_pair(0, 0, 4095, 4095, 255, 0, 0, 4095, 4095, 255),    // full frame
			box_pair(0, 0, 4095, 4095, 0, 2000, 2000, 2001, 2001, 0),  // tiny inside huge
			box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),                    // empty union
			box_pair(5, 5, 5, 50, 2, 5, 5, 5, 50, 2),                  // zero width
			box_pair(200, 200, 100, 100, 4, 100, 100, 200, 200, 4),    // inverted track
			box_pair(0, 0, 10, 10, 4, 300, 0, 0, 10, 4),               // negative union
			box_pair(4095, 4095, 0, 0, 255, 0, 0, 4095, 4095, 255),    // inverted full frame
			box_pair(4095, 0, 4095, 4095, 128, 0, 4095, 4095, 4095, 128),
			box_pair(0, 0, 3, 3, 1, 1, 1, 2, 2, 1),                    // one ninth
			box_pair(0, 0, 4095, 1, 0, 0, 0, 1, 4095, 0),              // thin cross
			box_pair(10, 10, 20, 20, 255, 10, 10, 20, 20, 0),          // class extremes
			box_pair(0, 0, 100, 100, 5, 0, 0, 100, 99, 5),             // just under one
			box_pair(1000, 2000, 3000, 4000, 6, 2000, 1000, 4095, 3000, 6)
		};
		foreach (directed_pairs[i])
			send_pair(directed_pairs[i]);

		// per-phase gate on/off and threshold: zero, one, above one, reset, random, half
		aware_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		thr_set   = '{17'd0, 17'd65536, 17'h1FFFF, 17'd19661,
			THRESH_BITS'($urandom_range(65536)), 17'd32768};

		for (int ph = 0; ph < 6; ph++) begin
			// every score back before the registers move
			drain_pipe();
			word    = $urandom;
			word[0] = aware_set[ph];
			apb_write(REG_CLASS_AWARE, word);
			word                  = $urandom;
			word[THRESH_BITS-1:0] = thr_set[ph];
			apb_write(REG_MATCH_THRESHOLD, word);

			case (ph / 2)
				0: begin
					tx_pct = 17;
					rx_pct = 56;
				end
				1: begin
					tx_pct = 56;
					rx_pct = 17;
				end
				default: begin
					tx_pct = 0;
					rx_pct = 0;
				end
			endcase
			// sender keeps offering while the receiver sits on its hands
			if (ph == 4)
				hold_req = 1'b1;

			repeat (PHASE_BEATS) send_pair(random_pair());
		end

		drain_pipe();
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
